/* src/ctt_pkg.sv */
// Shared token kinds, character codes, queue sizing and byte classifiers for the tokenizer.
package ctt_pkg;

    typedef enum logic [3:0] {
        K_END      = 4'd0,
        K_ERROR    = 4'd1,
        K_IDENT    = 4'd2,
        K_STRING   = 4'd3,
        K_LBRACE   = 4'd4,
        K_RBRACE   = 4'd5,
        K_LBRACKET = 4'd6,
        K_RBRACKET = 4'd7,
        K_COMMA    = 4'd8,
        K_EQUALS   = 4'd9
    } t_kind;

    localparam int OFFSET_BITS_DEF   = 24;
    localparam int LINE_COL_BITS_DEF = 16;
    localparam int KIND_W            = 4;

    // Result queue: four entries, two writes and one read per cycle.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_EQUALS   = 8'h3D;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    // Returns K_END when the byte is not one of the six punctuation marks.
    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            CH_LBRACE:   k = K_LBRACE;
            CH_RBRACE:   k = K_RBRACE;
            CH_LBRACKET: k = K_LBRACKET;
            CH_RBRACKET: k = K_RBRACKET;
            CH_COMMA:    k = K_COMMA;
            CH_EQUALS:   k = K_EQUALS;
            default:     k = K_END;
        endcase
        return k;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic logic is_ident_tail(input logic [7:0] c);
        return is_alpha(c) || (c >= CH_ZERO && c <= CH_NINE) || c == CH_UNDER || c == CH_DASH;
    endfunction

endpackage

/* src/ctt_queue.sv */
// Four-entry result queue that takes up to two results per cycle and delivers one.
module ctt_queue import ctt_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  logic [WIDTH-1:0]  i_data0,
    input  logic [WIDTH-1:0]  i_data1,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WIDTH-1:0]  o_data,
    output logic [QCNT_W-1:0] o_count
);

    logic [WIDTH-1:0]  r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wptr] <= i_data0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[QPTR_W'(r_wptr + 1'b1)] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= QPTR_W'(r_wptr + QPTR_W'(i_push_cnt));
            r_rptr  <= QPTR_W'(r_rptr + QPTR_W'(w_pop));
            r_count <= QCNT_W'(r_count + QCNT_W'(i_push_cnt) - QCNT_W'(w_pop));
        end
    end

endmodule

/* src/ctt_scan.sv */
// Input register, scan mode and position tracking, and decoding of up to two tokens per byte.
module ctt_scan import ctt_pkg::*; #(
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
    parameter int LINE_COL_BITS = LINE_COL_BITS_DEF,
    parameter int TOK_W         = KIND_W + 2 * OFFSET_BITS + 2 * LINE_COL_BITS + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_char_byte,
    input  logic             i_end_of_input,
    output logic [1:0]       o_push_cnt,
    output logic [TOK_W-1:0] o_tok0,
    output logic [TOK_W-1:0] o_tok1
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_STRING,
        MODE_COMMENT
    } t_mode;

    localparam logic [LINE_COL_BITS-1:0] LC_ONE = LINE_COL_BITS'(1);

    t_mode                    r_mode, n_mode;
    logic [OFFSET_BITS-1:0]   r_pos, n_pos;
    logic [LINE_COL_BITS-1:0] r_line, n_line;
    logic [LINE_COL_BITS-1:0] r_col, n_col;
    logic [OFFSET_BITS-1:0]   r_pstart, n_pstart;
    logic [LINE_COL_BITS-1:0] r_pline, n_pline;
    logic [LINE_COL_BITS-1:0] r_pcol, n_pcol;
    logic                     r_in_valid;
    logic [7:0]               r_char;
    logic                     r_eoi;

    logic [OFFSET_BITS-1:0]   w_pos_inc;
    logic [LINE_COL_BITS-1:0] w_line_inc;
    logic [LINE_COL_BITS-1:0] w_col_inc;
    logic [OFFSET_BITS-1:0]   w_pend_len;
    t_kind                    w_punct;
    logic                     w_has_pre, w_has_fall, w_fall_go;
    t_kind                    w_pre_kind, w_fall_kind;
    logic [OFFSET_BITS-1:0]   w_fall_len;
    logic [TOK_W-1:0]         w_pre_tok, w_fall_tok;

    function automatic logic [TOK_W-1:0] pack_tok(
        input t_kind                    kind,
        input logic [OFFSET_BITS-1:0]   off,
        input logic [OFFSET_BITS-1:0]   len,
        input logic [LINE_COL_BITS-1:0] line,
        input logic [LINE_COL_BITS-1:0] col,
        input logic                     last
    );
        return {kind, off, len, line, col, last};
    endfunction

    assign w_pos_inc  = (r_pos == '1) ? r_pos : OFFSET_BITS'(r_pos + 1'b1);
    assign w_line_inc = (r_line == '1) ? r_line : LINE_COL_BITS'(r_line + 1'b1);
    assign w_col_inc  = (r_col == '1) ? r_col : LINE_COL_BITS'(r_col + 1'b1);
    assign w_pend_len = (r_pos >= r_pstart) ? OFFSET_BITS'(r_pos - r_pstart) : '0;
    assign w_punct    = punct_kind(r_char);

    always_comb begin
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_line      = r_line;
        n_col       = r_col;
        n_pstart    = r_pstart;
        n_pline     = r_pline;
        n_pcol      = r_pcol;
        w_has_pre   = 1'b0;
        w_pre_kind  = K_ERROR;
        w_has_fall  = 1'b0;
        w_fall_kind = K_ERROR;
        w_fall_len  = OFFSET_BITS'(1);
        w_fall_go   = 1'b0;
        if (r_in_valid) begin
            if (r_eoi) begin
                // Flush an open token, then the end token; all state returns to reset.
                w_has_pre   = (r_mode == MODE_IDENT) || (r_mode == MODE_STRING);
                w_pre_kind  = (r_mode == MODE_IDENT) ? K_IDENT : K_ERROR;
                w_has_fall  = 1'b1;
                w_fall_kind = K_END;
                w_fall_len  = '0;
                n_mode      = MODE_IDLE;
                n_pos       = '0;
                n_line      = LC_ONE;
                n_col       = LC_ONE;
                n_pstart    = '0;
                n_pline     = LC_ONE;
                n_pcol      = LC_ONE;
            end else begin
                n_pos = w_pos_inc;
                if (r_char == CH_NL) begin
                    n_line = w_line_inc;
                    n_col  = LC_ONE;
                end else begin
                    n_col = w_col_inc;
                end
                case (r_mode)
                    MODE_IDENT: begin
                        if (!is_ident_tail(r_char)) begin
                            w_has_pre  = 1'b1;
                            w_pre_kind = K_IDENT;
                            n_mode     = MODE_IDLE;
                            w_fall_go  = 1'b1;
                        end
                    end
                    MODE_STRING: begin
                        if (r_char == CH_QUOTE) begin
                            w_has_pre  = 1'b1;
                            w_pre_kind = K_STRING;
                            n_mode     = MODE_IDLE;
                        end else if (r_char == CH_NL || r_char == CH_CR ||
                                     r_char == CH_BSLASH) begin
                            w_has_pre  = 1'b1;
                            w_pre_kind = K_ERROR;
                            n_mode     = MODE_IDLE;
                            w_fall_go  = 1'b1;
                        end
                    end
                    MODE_COMMENT: begin
                        if (r_char == CH_NL) begin
                            n_mode    = MODE_IDLE;
                            w_fall_go = 1'b1;
                        end
                    end
                    default: begin
                        w_fall_go = 1'b1;
                    end
                endcase
                if (w_fall_go) begin
                    if (is_space(r_char)) begin
                        n_mode = MODE_IDLE;
                    end else if (r_char == CH_HASH) begin
                        n_mode = MODE_COMMENT;
                    end else if (w_punct != K_END) begin
                        w_has_fall  = 1'b1;
                        w_fall_kind = w_punct;
                    end else if (r_char == CH_QUOTE) begin
                        n_pstart = w_pos_inc;
                        n_pline  = r_line;
                        n_pcol   = r_col;
                        n_mode   = MODE_STRING;
                    end else if (is_alpha(r_char) || r_char == CH_UNDER) begin
                        n_pstart = r_pos;
                        n_pline  = r_line;
                        n_pcol   = r_col;
                        n_mode   = MODE_IDENT;
                    end else begin
                        w_has_fall  = 1'b1;
                        w_fall_kind = K_ERROR;
                    end
                end
            end
        end
    end

    assign w_pre_tok  = pack_tok(w_pre_kind, r_pstart, w_pend_len, r_pline, r_pcol,
                                 !w_has_fall);
    assign w_fall_tok = pack_tok(w_fall_kind, r_pos, w_fall_len, r_line, r_col, 1'b1);
    assign o_tok0     = w_has_pre ? w_pre_tok : w_fall_tok;
    assign o_tok1     = w_fall_tok;
    assign o_push_cnt = 2'(w_has_pre) + 2'(w_has_fall);

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_char <= i_char_byte;
            r_eoi  <= i_end_of_input;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_pos      <= '0;
            r_line     <= LC_ONE;
            r_col      <= LC_ONE;
            r_pstart   <= '0;
            r_pline    <= LC_ONE;
            r_pcol     <= LC_ONE;
        end else begin
            r_in_valid <= i_accept;
            r_mode     <= n_mode;
            r_pos      <= n_pos;
            r_line     <= n_line;
            r_col      <= n_col;
            r_pstart   <= n_pstart;
            r_pline    <= n_pline;
            r_pcol     <= n_pcol;
        end
    end

endmodule

/* src/config_text_tokenizer.sv */
// Top level of the configuration text tokenizer: scanner stage, result queue and ports.
// Timing: an input beat is decoded in the cycle after it is accepted, from the scanner's
// input register; its results are then written into the queue and leave from its head.
// Throughput: one input beat per cycle while the queue has room; input waits while queued
// plus newly pushed results exceed two; two-result beats can cause this with a ready receiver.
// Reset: i_rst_n is synchronous and active low; it empties the queue and sets idle mode,
// offset 0, line 1 and column 1.
module config_text_tokenizer import ctt_pkg::*; #(
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
    parameter int LINE_COL_BITS = LINE_COL_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_char_byte,
    input  logic                     i_end_of_input,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [KIND_W-1:0]        o_token_kind,
    output logic [OFFSET_BITS-1:0]   o_start_offset,
    output logic [OFFSET_BITS-1:0]   o_token_length,
    output logic [LINE_COL_BITS-1:0] o_token_line,
    output logic [LINE_COL_BITS-1:0] o_token_column,
    output logic                     o_last_of_run
);

    // A result entry is packed as kind, offset, length, line, column, last flag (MSB first).
    localparam int TOK_W    = KIND_W + 2 * OFFSET_BITS + 2 * LINE_COL_BITS + 1;
    localparam int KIND_HI  = TOK_W - 1;
    localparam int OFF_HI   = KIND_HI - KIND_W;
    localparam int LEN_HI   = OFF_HI - OFFSET_BITS;
    localparam int LINE_HI  = LEN_HI - OFFSET_BITS;
    localparam int COL_HI   = LINE_HI - LINE_COL_BITS;

    logic              w_accept;
    logic [1:0]        w_push_cnt;
    logic [TOK_W-1:0]  w_tok0, w_tok1, w_head;
    logic [QCNT_W-1:0] w_count;

    // The scanner pushes the results of the beat held in its input register this cycle.
    // A new beat is taken only if, even without a pop, two queue slots stay free for it;
    // the decision uses registered state alone, so the two channels stay decoupled.
    assign o_in_ready = ({1'b0, w_count} + {{(QCNT_W - 1){1'b0}}, w_push_cnt})
                        <= (QCNT_W + 1)'(QDEPTH - 2);
    assign w_accept   = i_in_valid && o_in_ready;

    ctt_scan #(
        .OFFSET_BITS  (OFFSET_BITS),
        .LINE_COL_BITS(LINE_COL_BITS),
        .TOK_W        (TOK_W)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_char_byte   (i_char_byte),
        .i_end_of_input(i_end_of_input),
        .o_push_cnt    (w_push_cnt),
        .o_tok0        (w_tok0),
        .o_tok1        (w_tok1)
    );

    // Results leave in order from the queue head; the head entry is held in registers.
    ctt_queue #(
        .WIDTH(TOK_W)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_cnt(w_push_cnt),
        .i_data0   (w_tok0),
        .i_data1   (w_tok1),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (w_head),
        .o_count   (w_count)
    );

    assign o_token_kind   = w_head[KIND_HI -: KIND_W];
    assign o_start_offset = w_head[OFF_HI -: OFFSET_BITS];
    assign o_token_length = w_head[LEN_HI -: OFFSET_BITS];
    assign o_token_line   = w_head[LINE_HI -: LINE_COL_BITS];
    assign o_token_column = w_head[COL_HI -: LINE_COL_BITS];
    assign o_last_of_run  = w_head[0];

    // The admission rule must keep the queue from ever overfilling.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    // A beat pushing two results must have been admitted with room for both.
    a_double_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_cnt == 2'd2 |-> w_count <= QCNT_W'(QDEPTH - 2) + QCNT_W'(o_out_valid && i_out_ready))
        else $error("two results pushed without room");

    // The end token is zero length and always closes its run.
    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == K_END |-> o_token_length == '0 && o_last_of_run)
        else $error("malformed end token");

    // Line and column saturate, so a delivered token never reports zero for either.
    a_line_col_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_token_line != '0 && o_token_column != '0)
        else $error("token line or column is zero");

endmodule

/* tb/sv/config_text_tokenizer_tb.sv */
// Self-checking testbench for the configuration text tokenizer, with its own token predictor.
module config_text_tokenizer_tb import ctt_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // The block is built with its default widths, so the predictor uses the same ones.
    localparam int OW = OFFSET_BITS_DEF;
    localparam int LW = LINE_COL_BITS_DEF;

    // Random beats after the directed table. The last QUIET_BEATS of them start no new random
    // gaps or stalls on either side.
    localparam int RANDOM_BEATS = 600;
    localparam int QUIET_BEATS  = 150;

    // The limit lies far above the slowest correct run, with every gap and stall at its longest.
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DIR_ROWS    = 26;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_NAME,
        SCAN_QUOTED,
        SCAN_REMARK
    } t_scan;

    typedef struct packed {
        t_kind         kind;
        logic [OW-1:0] off;
        logic [OW-1:0] len;
        logic [LW-1:0] line;
        logic [LW-1:0] col;
        logic          last;
    } t_token;

    // One row of the directed table. Where typed is set, want is the token that this
    // beat must produce, written out by hand; otherwise the predictor decides.
    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       typed;
        t_token     want;
    } t_row;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    logic [7:0]     i_char_byte;
    logic           i_end_of_input;
    logic           o_out_valid;
    logic           i_out_ready;
    logic [3:0]     o_token_kind;
    logic [OW-1:0]  o_start_offset;
    logic [OW-1:0]  o_token_length;
    logic [LW-1:0]  o_token_line;
    logic [LW-1:0]  o_token_column;
    logic           o_last_of_run;

    config_text_tokenizer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_byte    (i_char_byte),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_token_line   (o_token_line),
        .o_token_column (o_token_column),
        .o_last_of_run  (o_last_of_run)
    );

    always #1 i_clk = ~i_clk;

    // Tokens that have been predicted but not yet seen on the output, oldest first.
    t_token tokens_due[$];

    t_row directed [DIR_ROWS];
    int   mismatches = 0;
    int   cycles     = 0;
    int   beats_sent = 0;
    bit   idle_on    = 1'b1;
    bit   drained    = 1'b0;
    int   ready_hold = 0;

    // Scanner state as the predictor sees it: the mode, the running position, and
    // where the identifier or string that is still open began.
    t_scan         scan;
    logic [OW-1:0] pos;
    logic [OW-1:0] tok_start;
    logic [LW-1:0] ln;
    logic [LW-1:0] cl;
    logic [LW-1:0] tok_ln;
    logic [LW-1:0] tok_cl;

    //--------------------------------------------------------------------------------------
    // Predictor
    //--------------------------------------------------------------------------------------

    function automatic void clear_scan();
        scan      = SCAN_IDLE;
        pos       = '0;
        ln        = LW'(1);
        cl        = LW'(1);
        tok_start = '0;
        tok_ln    = LW'(1);
        tok_cl    = LW'(1);
    endfunction

    // Offset, line and column all stick at their top values instead of wrapping.
    function automatic logic [OW-1:0] sat_off(input logic [OW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [LW-1:0] sat_lc(input logic [LW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic bit letter(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic bit name_char(input logic [7:0] c);
        return letter(c) || (c >= CH_ZERO && c <= CH_NINE) || c == CH_UNDER || c == CH_DASH;
    endfunction

    function automatic bit blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // K_END stands for "not punctuation" here, as no byte ever maps to it.
    function automatic t_kind punct_of(input logic [7:0] c);
        case (c)
            CH_LBRACE:   return K_LBRACE;
            CH_RBRACE:   return K_RBRACE;
            CH_LBRACKET: return K_LBRACKET;
            CH_RBRACKET: return K_RBRACKET;
            CH_COMMA:    return K_COMMA;
            CH_EQUALS:   return K_EQUALS;
            default:     return K_END;
        endcase
    endfunction

    function automatic void push_token(input t_kind k, input logic [OW-1:0] o,
                                       input logic [OW-1:0] n, input logic [LW-1:0] l,
                                       input logic [LW-1:0] c);
        t_token t;
        t.kind = k;
        t.off  = o;
        t.len  = n;
        t.line = l;
        t.col  = c;
        t.last = 1'b0;
        tokens_due.push_back(t);
    endfunction

    // Emits the identifier or string that is still open, reported from where it began.
    function automatic void push_open(input t_kind k);
        push_token(k, tok_start, (pos >= tok_start) ? pos - tok_start : '0, tok_ln, tok_cl);
    endfunction

    function automatic void step_pos(input logic [7:0] c);
        pos = sat_off(pos);
        if (c == CH_NL) begin
            ln = sat_lc(ln);
            cl = LW'(1);
        end else begin
            cl = sat_lc(cl);
        end
    endfunction

    // Works out the tokens that one accepted beat causes and queues them.
    function automatic void predict_beat(input logic [7:0] c, input logic eoi);
        int     first;
        bit     rescan;
        t_kind  pk;
        t_token t;
        first = tokens_due.size();
        if (eoi) begin
            // An open identifier is flushed as-is; an open string was never closed, so
            // it comes out as an error. The end token follows, and everything restarts.
            if (scan == SCAN_NAME) begin
                push_open(K_IDENT);
            end else if (scan == SCAN_QUOTED) begin
                push_open(K_ERROR);
            end
            push_token(K_END, pos, '0, ln, cl);
            clear_scan();
        end else begin
            rescan = 1'b1;
            case (scan)
                SCAN_NAME: begin
                    if (name_char(c)) begin
                        rescan = 1'b0;
                    end else begin
                        // The byte that ends the identifier gets its own idle handling,
                        // which is how one beat can yield two tokens.
                        push_open(K_IDENT);
                        scan = SCAN_IDLE;
                    end
                end
                SCAN_QUOTED: begin
                    if (c == CH_QUOTE) begin
                        push_open(K_STRING);
                        scan   = SCAN_IDLE;
                        rescan = 1'b0;
                    end else if (c != CH_NL && c != CH_CR && c != CH_BSLASH) begin
                        rescan = 1'b0;
                    end else begin
                        push_open(K_ERROR);
                        scan = SCAN_IDLE;
                    end
                end
                SCAN_REMARK: begin
                    if (c != CH_NL) begin
                        rescan = 1'b0;
                    end else begin
                        scan = SCAN_IDLE;
                    end
                end
                default: ;
            endcase
            if (rescan) begin
                pk = punct_of(c);
                if (blank(c)) begin
                    // Whitespace only moves the position.
                end else if (c == CH_HASH) begin
                    scan = SCAN_REMARK;
                end else if (pk != K_END) begin
                    push_token(pk, pos, OW'(1), ln, cl);
                end else if (c == CH_QUOTE) begin
                    // String text starts on the byte after the quote, but the token is
                    // placed at the quote's line and column.
                    tok_start = sat_off(pos);
                    tok_ln    = ln;
                    tok_cl    = cl;
                    scan      = SCAN_QUOTED;
                end else if (letter(c) || c == CH_UNDER) begin
                    tok_start = pos;
                    tok_ln    = ln;
                    tok_cl    = cl;
                    scan      = SCAN_NAME;
                end else begin
                    push_token(K_ERROR, pos, OW'(1), ln, cl);
                end
            end
            step_pos(c);
        end
        if (tokens_due.size() > first) begin
            t      = tokens_due.pop_back();
            t.last = 1'b1;
            tokens_due.push_back(t);
        end
    endfunction

    // A hand-written token for the directed table. Every such row yields one token,
    // so it is always the last of its beat.
    function automatic t_token typed_token(input t_kind k, input int o, input int n,
                                           input int l, input int c);
        t_token t;
        t.kind = k;
        t.off  = OW'(o);
        t.len  = OW'(n);
        t.line = LW'(l);
        t.col  = LW'(c);
        t.last = 1'b1;
        return t;
    endfunction

    //--------------------------------------------------------------------------------------
    // Checking
    //--------------------------------------------------------------------------------------

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("cycle %0d: %s", cycles, msg);
    endtask

    // Every output beat is held against the oldest predicted token, field by field.
    task automatic check_token();
        t_token want;
        if (tokens_due.size() == 0) begin
            note_mismatch($sformatf("unexpected token kind %0d at offset %0d",
                                    o_token_kind, o_start_offset));
        end else begin
            want = tokens_due.pop_front();
            if (o_token_kind !== want.kind) begin
                note_mismatch($sformatf("kind %0d, expected %0d", o_token_kind, want.kind));
            end
            if (o_start_offset !== want.off) begin
                note_mismatch($sformatf("offset %0d, expected %0d", o_start_offset, want.off));
            end
            if (o_token_length !== want.len) begin
                note_mismatch($sformatf("length %0d, expected %0d", o_token_length, want.len));
            end
            if (o_token_line !== want.line) begin
                note_mismatch($sformatf("line %0d, expected %0d", o_token_line, want.line));
            end
            if (o_token_column !== want.col) begin
                note_mismatch($sformatf("column %0d, expected %0d", o_token_column, want.col));
            end
            if (o_last_of_run !== want.last) begin
                note_mismatch($sformatf("last flag %0b, expected %0b", o_last_of_run,
                                        want.last));
            end
        end
    endtask

    // Outputs are sampled at the rising edge, before the block's own updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_token();
        end
    end

    // Hard stop in case the block hangs or loses a token.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("config_text_tokenizer: mismatch");
            $finish;
        end
    end

    // The token receiver stalls in random bursts while idling is on, and is ready otherwise.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_hold > 0) begin
                ready_hold--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                ready_hold = $urandom_range(1, 19);
            end
            i_out_ready <= (ready_hold == 0);
        end
    end

    //--------------------------------------------------------------------------------------
    // Stimulus
    //--------------------------------------------------------------------------------------

    // Offers one beat, holds it until the block takes it, then predicts its tokens. It is
    // entered and left at a falling edge. A gap drops valid first, so valid never gets
    // two assignments in one time step.
    task automatic send_beat(input logic [7:0] ch, input logic eoi,
                             input logic typed = 1'b0, input t_token want = '0);
        int first;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_char_byte    <= ch;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (!o_in_ready);
        first = tokens_due.size();
        predict_beat(ch, eoi);
        if (typed) begin
            // The hand-written token stands in place of the predicted one.
            while (tokens_due.size() > first) void'(tokens_due.pop_back());
            tokens_due.push_back(want);
        end
        beats_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_name_char(input bit lead);
        case ($urandom_range(0, lead ? 2 : 4))
            0:       return CH_UPPER_A + 8'($urandom_range(0, 25));
            1:       return CH_LOWER_A + 8'($urandom_range(0, 25));
            2:       return CH_UNDER;
            3:       return CH_ZERO + 8'($urandom_range(0, 9));
            default: return CH_DASH;
        endcase
    endfunction

    // Sends one randomly chosen piece of text. Most pieces are well-formed identifiers,
    // strings, punctuation, whitespace and comments so that every scan mode is reached;
    // the rest are broken strings, stray bytes of any value and end markers.
    task automatic send_fragment();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            send_beat(pick_name_char(1'b1), 1'b0);
            repeat ($urandom_range(0, 7)) send_beat(pick_name_char(1'b0), 1'b0);
        end else if (pick < 45) begin
            send_beat(CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 6)) begin
                do b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == CH_NL || b == CH_CR || b == CH_BSLASH);
                send_beat(b, 1'b0);
            end
            // Half of the strings close; the rest run into a forbidden byte or the end marker.
            case ($urandom_range(0, 7))
                0:       send_beat(CH_NL, 1'b0);
                1:       send_beat(CH_CR, 1'b0);
                2:       send_beat(CH_BSLASH, 1'b0);
                3:       send_beat(8'($urandom_range(0, 255)), 1'b1);
                default: send_beat(CH_QUOTE, 1'b0);
            endcase
        end else if (pick < 60) begin
            case ($urandom_range(0, 5))
                0:       send_beat(CH_LBRACE, 1'b0);
                1:       send_beat(CH_RBRACE, 1'b0);
                2:       send_beat(CH_LBRACKET, 1'b0);
                3:       send_beat(CH_RBRACKET, 1'b0);
                4:       send_beat(CH_COMMA, 1'b0);
                default: send_beat(CH_EQUALS, 1'b0);
            endcase
        end else if (pick < 70) begin
            b = 8'($urandom_range(0, 5));
            send_beat((b == 8'd5) ? CH_SPACE : CH_TAB + b, 1'b0);
        end else if (pick < 77) begin
            send_beat(CH_HASH, 1'b0);
            repeat ($urandom_range(0, 5)) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
                send_beat(b, 1'b0);
            end
            send_beat(CH_NL, 1'b0);
        end else if (pick < 87) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 90) begin
            send_beat(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            send_beat(CH_NL, 1'b0);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_char_byte    = 8'h00;
        i_end_of_input = 1'b0;
        clear_scan();

        // Directed part. The first rows run straight out of reset, so their tokens can
        // be written down directly: all six punctuation marks and the byte extremes as
        // error tokens, each one column further along line 1. After that come
        // whitespace, a newline, an identifier with a hyphen and a digit that is ended
        // by punctuation (two tokens in one beat), an empty string, a string broken by a
        // carriage return, one broken by a backslash (which is then an error token of
        // its own), a comment holding nothing, an identifier flushed by the end marker,
        // and an end marker on a freshly reset scanner.
        directed = '{
            '{CH_LBRACE,   1'b0, 1'b1, typed_token(K_LBRACE,   0, 1, 1, 1)},
            '{8'hFF,       1'b0, 1'b1, typed_token(K_ERROR,    1, 1, 1, 2)},
            '{8'h00,       1'b0, 1'b1, typed_token(K_ERROR,    2, 1, 1, 3)},
            '{CH_RBRACE,   1'b0, 1'b1, typed_token(K_RBRACE,   3, 1, 1, 4)},
            '{CH_LBRACKET, 1'b0, 1'b1, typed_token(K_LBRACKET, 4, 1, 1, 5)},
            '{CH_RBRACKET, 1'b0, 1'b1, typed_token(K_RBRACKET, 5, 1, 1, 6)},
            '{CH_COMMA,    1'b0, 1'b1, typed_token(K_COMMA,    6, 1, 1, 7)},
            '{CH_EQUALS,   1'b0, 1'b1, typed_token(K_EQUALS,   7, 1, 1, 8)},
            '{CH_SPACE,    1'b0, 1'b0, '0},
            '{CH_TAB,      1'b0, 1'b0, '0},
            '{CH_NL,       1'b0, 1'b0, '0},
            '{CH_UPPER_A,  1'b0, 1'b0, '0},
            '{CH_DASH,     1'b0, 1'b0, '0},
            '{CH_NINE,     1'b0, 1'b0, '0},
            '{CH_EQUALS,   1'b0, 1'b0, '0},
            '{CH_QUOTE,    1'b0, 1'b0, '0},
            '{CH_QUOTE,    1'b0, 1'b0, '0},
            '{CH_QUOTE,    1'b0, 1'b0, '0},
            '{CH_CR,       1'b0, 1'b0, '0},
            '{CH_QUOTE,    1'b0, 1'b0, '0},
            '{CH_BSLASH,   1'b0, 1'b0, '0},
            '{CH_HASH,     1'b0, 1'b0, '0},
            '{CH_NL,       1'b0, 1'b0, '0},
            '{CH_UNDER,    1'b0, 1'b0, '0},
            '{8'h00,       1'b1, 1'b0, '0},
            '{8'hFF,       1'b1, 1'b1, typed_token(K_END,      0, 0, 1, 1)}
        };

        // Synchronous reset, released at a falling edge and never asserted again.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            send_beat(directed[i].ch, directed[i].eoi, directed[i].typed, directed[i].want);
        end

        // Random part. Once, partway through, and now and then by chance, the sender
        // holds off until every predicted token has come out, so the block also sees
        // beats arriving into a completely empty pipeline.
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            if (beats_sent >= RANDOM_BEATS - QUIET_BEATS) begin
                idle_on = 1'b0;
            end
            if ((!drained && beats_sent >= 200) || $urandom_range(0, 149) == 0) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
                while (tokens_due.size() != 0) @(negedge i_clk);
                drained = 1'b1;
            end
            send_fragment();
        end

        i_in_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        // Wait on past the last expected token, to catch any stray extra token.
        repeat (16) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("config_text_tokenizer: match");
        end else begin
            $display("config_text_tokenizer: mismatch");
        end
        $finish;
    end

endmodule
